[rtl/dms_pkg.sv]
package dms_pkg;

  // Longest list that is compared; later positions are ignored.
  localparam int MAX_MODES = 64;
  // Position counter holds the value MAX_MODES itself when it saturates.
  localparam int POS_W     = $clog2(MAX_MODES + 1);
  localparam int IDX_W     = 6;
  localparam int DIM_W     = 16;
  localparam int DIST_W    = 2 * DIM_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

  typedef struct packed {
    logic [DIM_W-1:0] mode_width;
    logic [DIM_W-1:0] mode_height;
    logic             last_mode;
  } dms_in_t;

  typedef struct packed {
    logic             exact_found;
    logic [IDX_W-1:0] exact_index;
    logic             fallback_found;
    logic [IDX_W-1:0] fallback_index;
    logic [DIM_W-1:0] fallback_width;
    logic [DIM_W-1:0] fallback_height;
    logic             cropped_found;
    logic [IDX_W-1:0] cropped_index;
  } dms_out_t;

  // Comparison of one mode against the framebuffer size.
  typedef struct packed {
    logic              is_exact;
    logic              is_larger;
    logic              fits;
    logic [DIST_W-1:0] sq_dist;
  } dms_eval_t;

endpackage

[rtl/display_mode_selector.sv]
// Display mode selector. Candidate display modes arrive one per input
// transaction and are checked against the framebuffer size held in the two
// configuration registers (index 0 width, index 1 height; cfg_ready is always
// high and a write to any other index is ignored). Over one list the block
// keeps the first exact match, a fallback (the latest mode larger in both
// dimensions, otherwise the mode of smallest squared size distance, ties
// kept by the earlier mode, frozen once an exact match is seen) and the first
// mode that fits within the framebuffer. The transaction flagged last_mode
// produces one result transaction and the list state then clears, so the
// next transaction starts a new list. Only the first MAX_MODES positions of
// a list are compared. The block takes one mode per clock cycle unless a
// last mode waits on a full output register. The single evaluation stage
// between the input and output registers forms two 16x16 squares, their
// 33-bit sum and the compare against the running best combinationally.
// Registers should be written only between lists.
module display_mode_selector import dms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  dms_in_t              in_data,

  output logic                 out_valid,
  input  logic                 out_ready,
  output dms_out_t             out_data,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0] fb_width_r;
  logic [DIM_W-1:0] fb_height_r;

  // Input register: the mode under evaluation.
  logic    s1_valid_r;
  dms_in_t s1_r;

  // Per-list state and its next values.
  logic [POS_W-1:0]  pos_r,         pos_nxt;
  logic              exact_hit_r,   exact_hit_nxt;
  logic [IDX_W-1:0]  exact_pos_r,   exact_pos_nxt;
  logic              best_valid_r,  best_valid_nxt;
  logic [IDX_W-1:0]  best_pos_r,    best_pos_nxt;
  logic [DIM_W-1:0]  best_w_r,      best_w_nxt;
  logic [DIM_W-1:0]  best_h_r,      best_h_nxt;
  logic [DIST_W-1:0] best_dist_r,   best_dist_nxt;
  logic              fit_hit_r,     fit_hit_nxt;
  logic [IDX_W-1:0]  fit_pos_r,     fit_pos_nxt;

  // Output register.
  logic     out_valid_r;
  dms_out_t out_data_r;
  dms_out_t res;

  dms_eval_t ev;
  logic      s1_adv;
  logic      s1_fire;
  logic      in_fire;
  logic      in_range;
  logic [IDX_W-1:0] cur_idx;

  assign cfg_ready = 1'b1;

  // The evaluation stage only stalls when it holds a last mode whose result
  // cannot yet be placed in the output register. Any other mode moves on, so
  // input transactions keep flowing while a result waits to be taken.
  assign s1_adv   = !s1_valid_r || !s1_r.last_mode || !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_range = (pos_r < POS_W'(MAX_MODES));
  assign cur_idx  = IDX_W'(pos_r);

  dms_eval u_eval (
    .mode_width  (s1_r.mode_width),
    .mode_height (s1_r.mode_height),
    .fb_width    (fb_width_r),
    .fb_height   (fb_height_r),
    .eval        (ev)
  );

  always_comb begin
    pos_nxt        = pos_r;
    exact_hit_nxt  = exact_hit_r;
    exact_pos_nxt  = exact_pos_r;
    best_valid_nxt = best_valid_r;
    best_pos_nxt   = best_pos_r;
    best_w_nxt     = best_w_r;
    best_h_nxt     = best_h_r;
    best_dist_nxt  = best_dist_r;
    fit_hit_nxt    = fit_hit_r;
    fit_pos_nxt    = fit_pos_r;

    if (s1_fire && in_range) begin
      // Once an exact match is held the fallback no longer moves.
      if (!exact_hit_r) begin
        if (ev.is_exact) begin
          exact_hit_nxt = 1'b1;
          exact_pos_nxt = cur_idx;
        end else if (ev.is_larger || (ev.sq_dist < best_dist_r)) begin
          // A mode larger in both dimensions wins outright and pins the best
          // distance at zero, so only another larger mode can replace it.
          best_valid_nxt = 1'b1;
          best_pos_nxt   = cur_idx;
          best_w_nxt     = s1_r.mode_width;
          best_h_nxt     = s1_r.mode_height;
          best_dist_nxt  = ev.is_larger ? '0 : ev.sq_dist;
        end
      end
      if (!fit_hit_r && ev.fits) begin
        fit_hit_nxt = 1'b1;
        fit_pos_nxt = cur_idx;
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    // The result reflects the list including the last mode itself; fields of
    // a choice that was never made read as zero.
    res.exact_found     = exact_hit_nxt;
    res.exact_index     = exact_hit_nxt  ? exact_pos_nxt : '0;
    res.fallback_found  = best_valid_nxt;
    res.fallback_index  = best_valid_nxt ? best_pos_nxt  : '0;
    res.fallback_width  = best_valid_nxt ? best_w_nxt    : '0;
    res.fallback_height = best_valid_nxt ? best_h_nxt    : '0;
    res.cropped_found   = fit_hit_nxt;
    res.cropped_index   = fit_hit_nxt    ? fit_pos_nxt   : '0;

    if (s1_fire && s1_r.last_mode) begin
      pos_nxt        = '0;
      exact_hit_nxt  = 1'b0;
      exact_pos_nxt  = '0;
      best_valid_nxt = 1'b0;
      best_pos_nxt   = '0;
      best_w_nxt     = '0;
      best_h_nxt     = '0;
      best_dist_nxt  = DIST_ONES;
      fit_hit_nxt    = 1'b0;
      fit_pos_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_width_r   <= '0;
      fb_height_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      pos_r        <= '0;
      exact_hit_r  <= 1'b0;
      exact_pos_r  <= '0;
      best_valid_r <= 1'b0;
      best_pos_r   <= '0;
      best_w_r     <= '0;
      best_h_r     <= '0;
      best_dist_r  <= DIST_ONES;
      fit_hit_r    <= 1'b0;
      fit_pos_r    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FB_WIDTH:  fb_width_r  <= cfg_data;
          REG_FB_HEIGHT: fb_height_r <= cfg_data;
          default:       ;
        endcase
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire && s1_r.last_mode) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      pos_r        <= pos_nxt;
      exact_hit_r  <= exact_hit_nxt;
      exact_pos_r  <= exact_pos_nxt;
      best_valid_r <= best_valid_nxt;
      best_pos_r   <= best_pos_nxt;
      best_w_r     <= best_w_nxt;
      best_h_r     <= best_h_nxt;
      best_dist_r  <= best_dist_nxt;
      fit_hit_r    <= fit_hit_nxt;
      fit_pos_r    <= fit_pos_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_fire && s1_r.last_mode) begin
      out_data_r <= res;
    end
  end

  // The position counter saturates at the list limit.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_MODES))
    else $error("position counter beyond list limit");

  // A finished list leaves clean state behind for the next one.
  a_list_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_r.last_mode) |=>
      (pos_r == '0) && !exact_hit_r && !best_valid_r && !fit_hit_r &&
      (best_dist_r == DIST_ONES))
    else $error("list state not cleared after last mode");

  // A result without a fallback carries zero fallback fields.
  a_no_fallback_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.fallback_found) |->
      (out_data_r.fallback_index == '0) && (out_data_r.fallback_width == '0) &&
      (out_data_r.fallback_height == '0))
    else $error("fallback fields set without a fallback");

  // A larger mode compared before any exact match, other than a last mode, leaves a zero best distance.
  a_larger_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && in_range && !exact_hit_r && ev.is_larger && !s1_r.last_mode) |=>
      best_valid_r && (best_dist_r == '0))
    else $error("larger mode did not become the fallback");

endmodule

[rtl/dms_eval.sv]
module dms_eval import dms_pkg::*; (
  input  logic [DIM_W-1:0] mode_width,
  input  logic [DIM_W-1:0] mode_height,
  input  logic [DIM_W-1:0] fb_width,
  input  logic [DIM_W-1:0] fb_height,
  output dms_eval_t        eval
);

  logic [DIM_W-1:0]   dw;
  logic [DIM_W-1:0]   dh;
  logic [2*DIM_W-1:0] dw_sq;
  logic [2*DIM_W-1:0] dh_sq;

  // Absolute differences always fit in the field width.
  assign dw = (mode_width  > fb_width)  ? mode_width  - fb_width  : fb_width  - mode_width;
  assign dh = (mode_height > fb_height) ? mode_height - fb_height : fb_height - mode_height;

  assign dw_sq = (2*DIM_W)'(dw) * (2*DIM_W)'(dw);
  assign dh_sq = (2*DIM_W)'(dh) * (2*DIM_W)'(dh);

  always_comb begin
    eval.is_exact  = (mode_width == fb_width) && (mode_height == fb_height);
    eval.is_larger = (mode_width > fb_width) && (mode_height > fb_height);
    eval.fits      = (mode_width <= fb_width) && (mode_height <= fb_height);
    eval.sq_dist   = DIST_W'(dw_sq) + DIST_W'(dh_sq);
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the display mode selector. Lists of candidate modes
// go in one per input transaction; a scoreboard model of the selection rules
// predicts the single result transaction that each list's final mode produces,
// and a monitor compares every result field by field against the oldest
// prediction.
module testbench;
  import dms_pkg::*;

  // Spare register indexes: writes to them must leave the framebuffer size alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  // Give the pipeline ample room to drain after the final result.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  dms_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  dms_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  // Scoreboard copy of the registers and of the per-list selection state.
  logic [DIM_W-1:0]  fb_w;
  logic [DIM_W-1:0]  fb_h;
  logic [POS_W-1:0]  list_pos;
  logic              exact_seen;
  logic [IDX_W-1:0]  exact_at;
  logic              best_seen;
  logic [IDX_W-1:0]  best_at;
  logic [DIM_W-1:0]  best_w;
  logic [DIM_W-1:0]  best_h;
  logic [DIST_W-1:0] best_dist;
  logic              fit_seen;
  logic [IDX_W-1:0]  fit_at;

  // Predicted results, oldest first.
  dms_out_t choices_due[$];

  int  mismatches = 0;
  int  quiet_cycles = 0;

  // Flow control knobs, written by the test sequence only.
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned hold_gen = 0;

  // Owned by the receiver process alone.
  int unsigned hold_seen = 0;
  int          hold_left = 0;

  display_mode_selector DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard model of the selection rules
  // ---------------------------------------------------------------------------

  function automatic void clear_list();
    list_pos   = '0;
    exact_seen = 1'b0;
    exact_at   = '0;
    best_seen  = 1'b0;
    best_at    = '0;
    best_w     = '0;
    best_h     = '0;
    best_dist  = DIST_ONES;
    fit_seen   = 1'b0;
    fit_at     = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DIM_W-1:0] val);
    case (idx)
      REG_FB_WIDTH:  fb_w = val;
      REG_FB_HEIGHT: fb_h = val;
      default: ;
    endcase
  endfunction

  function automatic void take_fallback(input dms_in_t m,
                                        input logic [DIST_W-1:0] sq_dist);
    best_seen = 1'b1;
    best_at   = list_pos[IDX_W-1:0];
    best_w    = m.mode_width;
    best_h    = m.mode_height;
    best_dist = sq_dist;
  endfunction

  // Folds one accepted mode into the list state and, on the final mode of a
  // list, queues the expected result and starts a fresh list.
  function automatic void track_mode(input dms_in_t m);
    logic [DIM_W-1:0]  dw;
    logic [DIM_W-1:0]  dh;
    logic [DIST_W-1:0] sq_dist;
    dms_out_t          res;
    // Positions past the end of the compare window are neither counted nor judged.
    if (list_pos < POS_W'(MAX_MODES)) begin
      // Once an exact match is in hand, the fallback no longer moves.
      if (!exact_seen) begin
        if (m.mode_width == fb_w && m.mode_height == fb_h) begin
          exact_seen = 1'b1;
          exact_at   = list_pos[IDX_W-1:0];
        end else if (m.mode_width > fb_w && m.mode_height > fb_h) begin
          // Larger in both dimensions wins outright, and the latest such mode is kept.
          take_fallback(m, '0);
        end else begin
          dw      = (m.mode_width > fb_w) ? m.mode_width - fb_w : fb_w - m.mode_width;
          dh      = (m.mode_height > fb_h) ? m.mode_height - fb_h : fb_h - m.mode_height;
          sq_dist = DIST_W'(dw) * DIST_W'(dw) + DIST_W'(dh) * DIST_W'(dh);
          // Strictly smaller only, so a tie keeps the earlier mode.
          if (sq_dist < best_dist) take_fallback(m, sq_dist);
        end
      end
      if (!fit_seen && m.mode_width <= fb_w && m.mode_height <= fb_h) begin
        fit_seen = 1'b1;
        fit_at   = list_pos[IDX_W-1:0];
      end
      list_pos = list_pos + POS_W'(1);
    end
    if (m.last_mode) begin
      // Fields of a choice that was never made read as zero.
      res.exact_found     = exact_seen;
      res.exact_index     = exact_seen ? exact_at : '0;
      res.fallback_found  = best_seen;
      res.fallback_index  = best_seen ? best_at : '0;
      res.fallback_width  = best_seen ? best_w : '0;
      res.fallback_height = best_seen ? best_h : '0;
      res.cropped_found   = fit_seen;
      res.cropped_index   = fit_seen ? fit_at : '0;
      choices_due.push_back(res);
      clear_list();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!rx_gaps) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 35);
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [DIM_W-1:0] want,
                                      input logic [DIM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    dms_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (choices_due.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        want = choices_due.pop_front();
        check_field("exact_found", DIM_W'(want.exact_found),
                    DIM_W'(out_data.exact_found));
        check_field("exact_index", DIM_W'(want.exact_index),
                    DIM_W'(out_data.exact_index));
        check_field("fallback_found", DIM_W'(want.fallback_found),
                    DIM_W'(out_data.fallback_found));
        check_field("fallback_index", DIM_W'(want.fallback_index),
                    DIM_W'(out_data.fallback_index));
        check_field("fallback_width", want.fallback_width, out_data.fallback_width);
        check_field("fallback_height", want.fallback_height, out_data.fallback_height);
        check_field("cropped_found", DIM_W'(want.cropped_found),
                    DIM_W'(out_data.cropped_found));
        check_field("cropped_index", DIM_W'(want.cropped_index),
                    DIM_W'(out_data.cropped_index));
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on any channel means
  // the block has locked up.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, choices_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one mode and waits for it to be taken. Valid is only dropped when a
  // gap is inserted, so back-to-back transactions keep it high throughout.
  task automatic send_mode(input dms_in_t m);
    if (tx_gaps && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    track_mode(m);
  endtask

  // Stops offering modes until every predicted result has been seen, then lets
  // the pipeline run dry of any modes that produce no result.
  task automatic await_results();
    in_valid <= 1'b0;
    while (choices_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Programs the framebuffer size once the block is quiet, optionally with
  // junk writes to the spare indexes in between.
  task automatic set_framebuffer(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                 input bit add_spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [DIM_W-1:0]     val [4];
    int                   n;
    idx[0] = REG_FB_WIDTH;
    val[0] = w;
    n      = 1;
    if (add_spare) begin
      idx[1] = REG_SPARE_2;
      val[1] = DIM_W'($urandom);
      idx[2] = REG_SPARE_3;
      val[2] = DIM_W'($urandom);
      n      = 3;
    end
    idx[n] = REG_FB_HEIGHT;
    val[n] = h;
    n++;
    await_results();
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic dms_in_t make_mode(input int w, input int h, input bit last);
    dms_in_t m;
    m.mode_width  = DIM_W'(w);
    m.mode_height = DIM_W'(h);
    m.last_mode   = last;
    return m;
  endfunction

  // A dimension drawn around the framebuffer size, so that ties, near misses
  // and both sides of every comparison come up often.
  function automatic logic [DIM_W-1:0] near_dim(input logic [DIM_W-1:0] fb);
    logic [DIM_W-1:0] d;
    case ($urandom_range(0, 7))
      0: d = fb;
      1: d = fb + DIM_W'($urandom_range(1, 3));
      2: d = fb - DIM_W'($urandom_range(1, 3));
      3: d = fb + DIM_W'($urandom_range(0, 2000));
      4: d = fb - DIM_W'($urandom_range(0, 2000));
      5: d = '0;
      6: d = '1;
      default: d = DIM_W'($urandom);
    endcase
    return d;
  endfunction

  function automatic dms_in_t random_mode(input bit last);
    dms_in_t m;
    if ($urandom_range(0, 99) < 12) begin
      m.mode_width  = fb_w;
      m.mode_height = fb_h;
    end else begin
      m.mode_width  = near_dim(fb_w);
      m.mode_height = near_dim(fb_h);
    end
    m.last_mode = last;
    return m;
  endfunction

  task automatic send_random_list(input int len);
    for (int k = 0; k < len; k++) send_mode(random_mode(k == len - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Framebuffer left at its reset size of zero by zero.
  task automatic test_reset_size();
    // A lone exact match, then a list whose larger mode is the fallback before an exact match.
    send_mode(make_mode(0, 0, 1'b1));
    send_mode(make_mode(65535, 65535, 1'b0));
    send_mode(make_mode(0, 0, 1'b1));
  endtask

  // Largest and smallest framebuffer and mode sizes, including the largest distance.
  task automatic test_extremes();
    set_framebuffer(16'hFFFF, 16'hFFFF, 1'b1);
    send_mode(make_mode(0, 0, 1'b0));
    send_mode(make_mode(0, 65535, 1'b0));
    send_mode(make_mode(65535, 65535, 1'b1));
    set_framebuffer(16'h0000, 16'hFFFF, 1'b0);
    send_mode(make_mode(65535, 0, 1'b0));
    send_mode(make_mode(0, 0, 1'b1));
  endtask

  task automatic test_fallback_rules();
    set_framebuffer(16'd1920, 16'd1080, 1'b0);
    // Equal distances keep the first; a strictly closer mode then takes over.
    send_mode(make_mode(1910, 1080, 1'b0));
    send_mode(make_mode(1930, 1080, 1'b0));
    send_mode(make_mode(1920, 1070, 1'b0));
    send_mode(make_mode(1921, 1080, 1'b1));
    // Latest larger mode wins until the exact match freezes the fallback.
    send_mode(make_mode(2560, 1440, 1'b0));
    send_mode(make_mode(1280, 720, 1'b0));
    send_mode(make_mode(3840, 2160, 1'b0));
    send_mode(make_mode(1920, 1080, 1'b0));
    send_mode(make_mode(4096, 2304, 1'b1));
    // Every mode overhangs in one dimension, so nothing can be cropped.
    send_mode(make_mode(1921, 100, 1'b0));
    send_mode(make_mode(100, 1081, 1'b1));
  endtask

  // The size changes partway through a list: the earlier choices stand and
  // the new size applies from the next mode on.
  task automatic test_midlist_config();
    set_framebuffer(16'd800, 16'd600, 1'b0);
    send_mode(make_mode(1024, 768, 1'b0));
    set_framebuffer(16'd1024, 16'd768, 1'b1);
    send_mode(make_mode(1024, 768, 1'b1));
  endtask

  // The receiver holds off for a long stretch while one-mode lists keep
  // coming, so the block fills and stalls its input; then the sender waits
  // for every outstanding result.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_gen++;
    for (int k = 0; k < 40; k++) send_random_list(1);
    tx_gaps = 1'b1;
    await_results();
  endtask

  // Lists that reach and run past the compare window.
  task automatic test_overlong_lists();
    dms_in_t m;
    set_framebuffer(DIM_W'($urandom_range(100, 60000)), DIM_W'($urandom_range(100, 60000)),
                    1'b0);
    // Every compared position is larger than the framebuffer; the exact,
    // fitting modes beyond the window must change nothing.
    for (int k = 0; k < 70; k++) begin
      if (k < MAX_MODES) begin
        m.mode_width  = fb_w + DIM_W'($urandom_range(1, 50));
        m.mode_height = fb_h + DIM_W'($urandom_range(1, 50));
      end else begin
        m.mode_width  = fb_w;
        m.mode_height = fb_h;
      end
      m.last_mode = (k == 69);
      send_mode(m);
    end
    // Exactly fills the window, ending on an exact match at the last position.
    for (int k = 0; k < MAX_MODES - 1; k++) send_mode(random_mode(1'b0));
    send_mode(make_mode(fb_w, fb_h, 1'b1));
    send_random_list($urandom_range(MAX_MODES + 1, MAX_MODES + 26));
  endtask

  // Random lists over a run of framebuffer sizes, the extremes among them.
  task automatic test_random_lists();
    int sent;
    int len;
    int r;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_framebuffer(16'd1920, 16'd1080, 1'b1);
        1: set_framebuffer(16'h0000, 16'h0000, 1'b0);
        2: set_framebuffer(16'hFFFF, 16'hFFFF, 1'b1);
        3: set_framebuffer(16'h0000, 16'hFFFF, 1'b0);
        4: set_framebuffer(16'hFFFF, 16'h0000, 1'b1);
        5: set_framebuffer(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)), 1'b0);
        default: set_framebuffer(DIM_W'($urandom), DIM_W'($urandom), p[0]);
      endcase
      // One phase runs flat out on both sides.
      tx_gaps = (p != 6);
      rx_gaps = (p != 6);
      sent = 0;
      while (sent < 105) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 6);
        else if (r < 95) len = $urandom_range(7, 30);
        else             len = $urandom_range(31, MAX_MODES);
        send_random_list(len);
        sent += len;
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    fb_w      = '0;
    fb_h      = '0;
    clear_list();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_size();
    test_extremes();
    test_fallback_rules();
    test_midlist_config();
    test_backpressure();
    test_overlong_lists();
    test_random_lists();

    await_results();
    if (mismatches == 0 && choices_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
